FILE: hw/rtl/adaptive_contrast_enhance_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive contrast enhancement unit
// Checks use the aclk clock and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_CONTRAST_ENHANCE_UNIT_ASSERT_SVH
`define ADAPTIVE_CONTRAST_ENHANCE_UNIT_ASSERT_SVH

// Same-cycle implication
`define ACE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ace: same-cycle check failed");

// Next-cycle implication
`define ACE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ace: next-cycle check failed");

`endif

FILE: hw/rtl/ace_pkg.sv
// ----------------------------------------------------------------------------
// ace_pkg
// Shared constants, codes, command and status types of the contrast unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ace_pkg;

    localparam int FRAME_ROWS  = 64;
    localparam int FRAME_COLS  = 64;
    localparam int MAX_WINDOW  = 15;
    localparam int POS_W       = 6;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = 2 * POS_W;
    localparam int STORE_DEPTH = FRAME_ROWS * FRAME_COLS;
    localparam int DIM_W       = 7;
    localparam int WIN_W       = 4;
    localparam int GAIN_W      = 8;
    localparam int SUM_W       = 20;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 19;
    localparam int DIV_CNT_W   = 6;
    localparam int SQRT_STEPS  = 16;
    localparam int CNT_W       = 5;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_ENHANCE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2,
        CFG_MAX_GAIN     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_MEAN  = 2'd0,
        DIV_VAR   = 2'd1,
        DIV_GMEAN = 2'd2,
        DIV_GAIN  = 2'd3
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BACK,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DIFF,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DIV_GMEAN,
        ST_DIV_GAIN,
        ST_PROD,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     sum_clr;
        logic     load;
        logic     capture;
        logic     set_err;
        logic     back;
        logic     rd_win;
        logic     row_end;
        logic     mul;
        logic     diff;
        logic     set_flat;
        logic     div_start;
        logic     div_latch;
        div_sel_t div_sel;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     prod;
        logic     final_res;
        logic     out_load;
    } ace_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       enh_bad;
        logic [2:0] half;
        logic       flat;
        logic       div_busy;
        logic       out_valid;
    } ace_stat_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             rev;
    } refl_t;

    // One step of a mirrored walk: edge index repeats, then direction flips
    function automatic refl_t refl_step(input logic [POS_W-1:0] pos, input logic rev,
                                        input logic [POS_W-1:0] last, input logic fwd);
        refl_t r;
        r.pos = pos;
        r.rev = rev;
        if (fwd ^ rev) begin
            if (pos == last) r.rev = ~rev;
            else             r.pos = pos + 1'b1;
        end else begin
            if (pos == '0) r.rev = ~rev;
            else           r.pos = pos - 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/adaptive_contrast_enhance_unit.sv
// ----------------------------------------------------------------------------
// adaptive_contrast_enhance_unit
// Clear and load items finish in the idle state; an enhance with a bad window goes
// straight to the output state. A good enhance backs up to the window corner, reads
// the store serially, runs four divisions and a square root, and a flat window
// skips the arithmetic. One item is in work at a time; a result that waits in the
// output register holds the next enhance in its output state.
// aresetn (synchronous) restores registers 64, 64, 3, 5 and a zero frame sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_contrast_enhance_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[1:0], row[7:2], col[13:8], pixel_in[21:14], zero fill above
    input  logic [ace_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // enhanced[7:0], flat_window[8], error[9], zero fill above
    output logic [ace_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [ace_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ace_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    ace_pkg::ace_cmd_t  cmd;
    ace_pkg::ace_stat_t stat;

    ace_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ace_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`include "adaptive_contrast_enhance_unit_assert.svh"

    // Divider is never restarted mid-run
    `ACE_ASSERT_IMP(a_div_start_idle, cmd.div_start, !stat.div_busy)
    // Output register is loaded only when free or draining
    `ACE_ASSERT_IMP(a_out_no_overwrite, cmd.out_load, !m_tvalid || m_tready)
    // A loaded result shows up on the next cycle
    `ACE_ASSERT_NXT(a_out_loaded, cmd.out_load, m_tvalid)
    // No item is taken while a division runs
    `ACE_ASSERT_IMP(a_busy_no_accept, stat.div_busy, !s_tready)

endmodule

FILE: hw/rtl/ace_ram.sv
// ----------------------------------------------------------------------------
// ace_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ace_ram #(
    parameter int WIDTH = ace_pkg::PIX_W,
    parameter int DEPTH = ace_pkg::STORE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ace_div.sv
// ----------------------------------------------------------------------------
// ace_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ace_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ace_pkg::DIV_NUM_W-1:0] num,
    input  logic [ace_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic [ace_pkg::DIV_NUM_W-1:0] quot
);

    localparam logic [ace_pkg::DIV_CNT_W-1:0] LAST_STEP =
        ace_pkg::DIV_CNT_W'(ace_pkg::DIV_NUM_W - 1);

    logic                          busy_reg;
    logic [ace_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [ace_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [ace_pkg::DIV_DEN_W-1:0] den_reg;
    logic [ace_pkg::DIV_NUM_W-1:0] quo_reg;
    logic [ace_pkg::DIV_DEN_W:0]   shifted;
    logic [ace_pkg::DIV_DEN_W:0]   diff;
    logic                          ge;

    // Bring down the next numerator bit and trial-subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[ace_pkg::DIV_NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[ace_pkg::DIV_DEN_W-1:0] : shifted[ace_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[ace_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

FILE: hw/rtl/ace_datapath.sv
// ----------------------------------------------------------------------------
// ace_datapath
// Frame store, window walk, statistics, root, divisions and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ace_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ace_pkg::ace_cmd_t              cmd,
    output ace_pkg::ace_stat_t             stat,
    // opcode[1:0], row[7:2], col[13:8], pixel_in[21:14], zero fill above
    input  logic [ace_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           cfg_wr_en,
    input  logic [ace_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ace_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    // enhanced[7:0], flat_window[8], error[9], zero fill above
    output logic [ace_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int PW = ace_pkg::POS_W;

    // Configuration
    logic [ace_pkg::DIM_W-1:0]  fw_reg;
    logic [ace_pkg::DIM_W-1:0]  fh_reg;
    logic [ace_pkg::WIN_W-1:0]  ws_reg;
    logic [ace_pkg::GAIN_W-1:0] mg_reg;
    logic [ace_pkg::DIM_W-1:0]  eff_w;
    logic [ace_pkg::DIM_W-1:0]  eff_h;
    logic [PW-1:0]              h_last;
    logic [PW-1:0]              w_last;

    // Input fields
    logic [1:0]                in_op;
    logic [PW-1:0]             in_row;
    logic [PW-1:0]             in_col;
    logic [ace_pkg::PIX_W-1:0] in_pix;
    logic                      in_frame;

    // Store and sums
    logic [ace_pkg::SUM_W-1:0] sum_reg;
    logic                      ram_we;
    logic [ace_pkg::ADDR_W-1:0] ram_raddr;
    logic [ace_pkg::PIX_W-1:0] ram_rdata;

    // Window walk
    ace_pkg::refl_t r_reg, c_reg, cs_reg;
    ace_pkg::refl_t r_back, c_back, r_fwd, c_fwd;
    logic                      cen_pend_reg;
    logic                      acc_vld_reg;
    logic [ace_pkg::PIX_W-1:0] centre_reg;
    logic [15:0]               s_reg;
    logic [23:0]               q_reg;
    logic [15:0]               sq;
    logic [7:0]                n_reg;

    // Statistics
    logic [31:0] nq_reg;
    logic [31:0] ss_reg;
    logic [31:0] d_reg;
    logic [15:0] mean_reg;
    logic [31:0] var_reg;
    logic [27:0] gmean_reg;
    logic [15:0] gain_reg;
    logic [15:0] nn;
    logic [13:0] wh;
    logic [15:0] dev;
    logic [18:0] dev5;
    logic [15:0] cap;
    logic [35:0] gq;
    logic [15:0] gain_next;

    // Divider
    logic [ace_pkg::DIV_NUM_W-1:0] div_num;
    logic [ace_pkg::DIV_DEN_W-1:0] div_den;
    logic                          div_busy;
    logic [ace_pkg::DIV_NUM_W-1:0] div_quot;

    // Square root
    logic [31:0] rad_reg;
    logic [15:0] root_reg;
    logic [16:0] rem_reg;
    logic [18:0] rem_sh;
    logic [18:0] trial;

    // Final mix
    logic signed [17:0] dpix;
    logic signed [34:0] prod_reg;
    logic signed [35:0] total;
    logic [7:0]         res_enh_reg;
    logic               res_flat_reg;
    logic               res_err_reg;
    logic               out_valid_reg;
    logic [ace_pkg::M_TDATA_W-1:0] out_data_reg;

    // Field unpack and frame bounds
    always_comb begin
        in_op  = s_tdata[1:0];
        in_row = s_tdata[7:2];
        in_col = s_tdata[13:8];
        in_pix = s_tdata[21:14];
        eff_w  = (fw_reg > ace_pkg::DIM_W'(ace_pkg::FRAME_COLS)) ?
                 ace_pkg::DIM_W'(ace_pkg::FRAME_COLS) : fw_reg;
        eff_h  = (fh_reg > ace_pkg::DIM_W'(ace_pkg::FRAME_ROWS)) ?
                 ace_pkg::DIM_W'(ace_pkg::FRAME_ROWS) : fh_reg;
        w_last = PW'(eff_w - 1'b1);
        h_last = PW'(eff_h - 1'b1);
        in_frame = ({1'b0, in_row} < eff_h) && ({1'b0, in_col} < eff_w);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 7'd64;
            fh_reg <= 7'd64;
            ws_reg <= 4'd3;
            mg_reg <= 8'd5;
        end else if (cfg_wr_en) begin
            unique case (ace_pkg::cfg_idx_t'(cfg_index))
                ace_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_wdata[ace_pkg::DIM_W-1:0];
                ace_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_wdata[ace_pkg::DIM_W-1:0];
                ace_pkg::CFG_WINDOW_SIZE:  ws_reg <= cfg_wdata[ace_pkg::WIN_W-1:0];
                ace_pkg::CFG_MAX_GAIN:     mg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame sum: clear or add the loaded pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (ram_we) begin
            sum_reg <= sum_reg + {12'b0, in_pix};
        end
    end

    assign ram_we    = cmd.load & in_frame;
    assign ram_raddr = cmd.capture ? {in_row, in_col} : {r_reg.pos, c_reg.pos};

    ace_ram #(
        .WIDTH (ace_pkg::PIX_W),
        .DEPTH (ace_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({in_row, in_col}),
        .wdata (in_pix),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Mirrored steps of the row and column walk
    always_comb begin
        r_back = ace_pkg::refl_step(r_reg.pos, r_reg.rev, h_last, 1'b0);
        c_back = ace_pkg::refl_step(c_reg.pos, c_reg.rev, w_last, 1'b0);
        r_fwd  = ace_pkg::refl_step(r_reg.pos, r_reg.rev, h_last, 1'b1);
        c_fwd  = ace_pkg::refl_step(c_reg.pos, c_reg.rev, w_last, 1'b1);
    end

    // Window position: back up to the corner, then scan row by row
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            r_reg  <= '{pos: in_row, rev: 1'b0};
            c_reg  <= '{pos: in_col, rev: 1'b0};
            cs_reg <= '{pos: in_col, rev: 1'b0};
            n_reg  <= {4'b0, ws_reg} * {4'b0, ws_reg};
        end else if (cmd.back) begin
            r_reg  <= r_back;
            c_reg  <= c_back;
            cs_reg <= c_back;
        end else if (cmd.rd_win) begin
            if (cmd.row_end) begin
                c_reg <= cs_reg;
                r_reg <= r_fwd;
            end else begin
                c_reg <= c_fwd;
            end
        end
    end

    // Read-return flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_pend_reg <= 1'b0;
            acc_vld_reg  <= 1'b0;
        end else begin
            cen_pend_reg <= cmd.capture;
            acc_vld_reg  <= cmd.rd_win;
        end
    end

    assign sq = {8'b0, ram_rdata} * {8'b0, ram_rdata};

    // Accumulate window sum and sum of squares
    always_ff @(posedge aclk) begin
        if (cen_pend_reg) begin
            centre_reg <= ram_rdata;
        end
        if (cmd.capture) begin
            s_reg <= '0;
            q_reg <= '0;
        end else if (acc_vld_reg) begin
            s_reg <= s_reg + {8'b0, ram_rdata};
            q_reg <= q_reg + {8'b0, sq};
        end
    end

    // N*Q and S*S, then their difference
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            nq_reg <= {24'b0, n_reg} * {8'b0, q_reg};
            ss_reg <= {16'b0, s_reg} * {16'b0, s_reg};
        end
        if (cmd.diff) begin
            d_reg <= nq_reg - ss_reg;
        end
    end

    // Divider operand select
    always_comb begin
        nn   = {8'b0, n_reg} * {8'b0, n_reg};
        wh   = {7'b0, eff_w} * {7'b0, eff_h};
        dev  = (root_reg == '0) ? 16'd1 : root_reg;
        dev5 = {3'b0, dev} * 19'd5;
        case (cmd.div_sel)
            ace_pkg::DIV_MEAN: begin
                div_num = {24'b0, s_reg, 8'b0};
                div_den = {11'b0, n_reg};
            end
            ace_pkg::DIV_VAR: begin
                div_num = {d_reg, 16'b0};
                div_den = {3'b0, nn};
            end
            ace_pkg::DIV_GMEAN: begin
                div_num = {20'b0, sum_reg, 8'b0};
                div_den = {5'b0, wh};
            end
            default: begin
                div_num = {12'b0, gmean_reg, 8'b0};
                div_den = dev5;
            end
        endcase
    end

    ace_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // Gain clamp: at most max_gain, at least one
    always_comb begin
        cap       = {mg_reg, 8'b0};
        gq        = div_quot[35:0];
        gain_next = (gq > {20'b0, cap}) ? cap : gq[15:0];
        if (gain_next < 16'd256) begin
            gain_next = 16'd256;
        end
    end

    // Latch quotients
    always_ff @(posedge aclk) begin
        if (cmd.div_latch) begin
            case (cmd.div_sel)
                ace_pkg::DIV_MEAN:  mean_reg  <= div_quot[15:0];
                ace_pkg::DIV_VAR:   var_reg   <= div_quot[31:0];
                ace_pkg::DIV_GMEAN: gmean_reg <= div_quot[27:0];
                default:            gain_reg  <= gain_next;
            endcase
        end
    end

    // Square root, two radicand bits per step
    always_comb begin
        rem_sh = {rem_reg, rad_reg[31:30]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg  <= var_reg;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[29:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= 17'(rem_sh - trial);
                root_reg <= {root_reg[14:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[16:0];
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end

    // Mix: mean + gain * (pixel - mean)
    always_comb begin
        dpix  = $signed({2'b0, centre_reg, 8'b0}) - $signed({2'b0, mean_reg});
        total = $signed({12'b0, mean_reg, 8'b0}) + $signed({prod_reg[34], prod_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            prod_reg <= dpix * $signed({1'b0, gain_reg});
        end
    end

    // Result selection
    always_ff @(posedge aclk) begin
        if (cmd.set_err) begin
            res_enh_reg  <= '0;
            res_flat_reg <= 1'b0;
            res_err_reg  <= 1'b1;
        end else if (cmd.set_flat) begin
            res_enh_reg  <= centre_reg;
            res_flat_reg <= 1'b1;
            res_err_reg  <= 1'b0;
        end else if (cmd.final_res) begin
            res_flat_reg <= 1'b0;
            res_err_reg  <= 1'b0;
            if (total[35]) begin
                res_enh_reg <= '0;
            end else if (|total[34:24]) begin
                res_enh_reg <= 8'd255;
            end else begin
                res_enh_reg <= total[23:16];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {6'b0, res_err_reg, res_flat_reg, res_enh_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status to the controller
    always_comb begin
        stat.op        = in_op;
        stat.enh_bad   = !ws_reg[0] || ({1'b0, ws_reg} > 5'(ace_pkg::MAX_WINDOW)) || !in_frame;
        stat.half      = ws_reg[3:1];
        stat.flat      = (nq_reg == ss_reg);
        stat.div_busy  = div_busy;
        stat.out_valid = out_valid_reg;
    end

endmodule

FILE: hw/rtl/ace_ctrl.sv
// ----------------------------------------------------------------------------
// ace_ctrl
// Controller: sequences load, window scan and the arithmetic of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ace_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    input  ace_pkg::ace_stat_t stat,
    output ace_pkg::ace_cmd_t  cmd
);

    ace_pkg::state_t state_reg, state_next;
    logic [ace_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]                rc_reg, rc_next;
    logic [3:0]                cc_reg, cc_next;
    logic [3:0]                side_last;
    logic                      row_end;
    logic                      accept;

    assign side_last = {stat.half, 1'b0};
    assign row_end   = (cc_reg == side_last);
    assign accept    = (state_reg == ace_pkg::ST_IDLE) && s_tvalid;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ace_pkg::ST_IDLE;
            cnt_reg   <= '0;
            rc_reg    <= '0;
            cc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rc_reg    <= rc_next;
            cc_reg    <= cc_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rc_next    = rc_reg;
        cc_next    = cc_reg;
        unique case (state_reg)
            ace_pkg::ST_IDLE: begin
                cnt_next = '0;
                rc_next  = '0;
                cc_next  = '0;
                if (accept && stat.op == ace_pkg::OP_ENHANCE) begin
                    if (stat.enh_bad)          state_next = ace_pkg::ST_OUT;
                    else if (stat.half == '0)  state_next = ace_pkg::ST_SCAN;
                    else                       state_next = ace_pkg::ST_BACK;
                end
            end
            ace_pkg::ST_BACK: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ace_pkg::CNT_W'(stat.half - 1'b1)) begin
                    cnt_next   = '0;
                    state_next = ace_pkg::ST_SCAN;
                end
            end
            ace_pkg::ST_SCAN: begin
                if (row_end) begin
                    cc_next = '0;
                    rc_next = rc_reg + 1'b1;
                    if (rc_reg == side_last) begin
                        state_next = ace_pkg::ST_DRAIN;
                    end
                end else begin
                    cc_next = cc_reg + 1'b1;
                end
            end
            ace_pkg::ST_DRAIN: state_next = ace_pkg::ST_MUL;
            ace_pkg::ST_MUL:   state_next = ace_pkg::ST_DIFF;
            ace_pkg::ST_DIFF: begin
                state_next = stat.flat ? ace_pkg::ST_OUT : ace_pkg::ST_DIV_MEAN;
            end
            ace_pkg::ST_DIV_MEAN, ace_pkg::ST_DIV_VAR,
            ace_pkg::ST_DIV_GMEAN, ace_pkg::ST_DIV_GAIN: begin
                if (cnt_reg == '0) begin
                    cnt_next = 5'd1;
                end else if (!stat.div_busy) begin
                    cnt_next = '0;
                    case (state_reg)
                        ace_pkg::ST_DIV_MEAN:  state_next = ace_pkg::ST_DIV_VAR;
                        ace_pkg::ST_DIV_VAR:   state_next = ace_pkg::ST_SQRT;
                        ace_pkg::ST_DIV_GMEAN: state_next = ace_pkg::ST_DIV_GAIN;
                        default:               state_next = ace_pkg::ST_PROD;
                    endcase
                end
            end
            ace_pkg::ST_SQRT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ace_pkg::CNT_W'(ace_pkg::SQRT_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ace_pkg::ST_DIV_GMEAN;
                end
            end
            ace_pkg::ST_PROD:  state_next = ace_pkg::ST_FINAL;
            ace_pkg::ST_FINAL: state_next = ace_pkg::ST_OUT;
            ace_pkg::ST_OUT: begin
                if (!stat.out_valid || m_tready) begin
                    state_next = ace_pkg::ST_IDLE;
                end
            end
            default: state_next = ace_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ace_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    case (stat.op)
                        ace_pkg::OP_CLEAR: cmd.sum_clr = 1'b1;
                        ace_pkg::OP_LOAD:  cmd.load    = 1'b1;
                        ace_pkg::OP_ENHANCE: begin
                            cmd.set_err = stat.enh_bad;
                            cmd.capture = !stat.enh_bad;
                        end
                        default: ;
                    endcase
                end
            end
            ace_pkg::ST_BACK: cmd.back = 1'b1;
            ace_pkg::ST_SCAN: begin
                cmd.rd_win  = 1'b1;
                cmd.row_end = row_end;
            end
            ace_pkg::ST_DRAIN: ;
            ace_pkg::ST_MUL:   cmd.mul = 1'b1;
            ace_pkg::ST_DIFF: begin
                cmd.diff     = 1'b1;
                cmd.set_flat = stat.flat;
            end
            ace_pkg::ST_DIV_MEAN, ace_pkg::ST_DIV_VAR,
            ace_pkg::ST_DIV_GMEAN, ace_pkg::ST_DIV_GAIN: begin
                case (state_reg)
                    ace_pkg::ST_DIV_MEAN:  cmd.div_sel = ace_pkg::DIV_MEAN;
                    ace_pkg::ST_DIV_VAR:   cmd.div_sel = ace_pkg::DIV_VAR;
                    ace_pkg::ST_DIV_GMEAN: cmd.div_sel = ace_pkg::DIV_GMEAN;
                    default:               cmd.div_sel = ace_pkg::DIV_GAIN;
                endcase
                cmd.div_start = (cnt_reg == '0);
                cmd.div_latch = (cnt_reg != '0) && !stat.div_busy;
            end
            ace_pkg::ST_SQRT: begin
                cmd.sqrt_init = (cnt_reg == '0);
                cmd.sqrt_step = (cnt_reg != '0);
            end
            ace_pkg::ST_PROD:  cmd.prod      = 1'b1;
            ace_pkg::ST_FINAL: cmd.final_res = 1'b1;
            ace_pkg::ST_OUT:   cmd.out_load  = !stat.out_valid || m_tready;
            default: ;
        endcase
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the adaptive contrast enhancement unit
// Drives clear, load and enhance transactions on the input stream, predicts
// every enhanced pixel with a behavioral copy of the frame store, frame sum
// and registers, and compares each output transaction field by field. Runs
// directed corner cases, repeated loads into the frame sum, random phases
// with varied idling and register settings, and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  DRAIN_WAIT  = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] opcode;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] pixel_in;
    } pix_cmd_t;

    typedef struct {
        logic [7:0] enhanced;
        logic       flat_window;
        logic       error;
    } pix_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ace_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ace_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [ace_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ace_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: frame store, written map, frame sum, registers
    logic [7:0]  pix_mem [ace_pkg::STORE_DEPTH];
    bit          pix_written [ace_pkg::STORE_DEPTH];
    logic [19:0] frame_sum_m;
    logic [6:0]  width_m, height_m;
    logic [3:0]  win_m;
    logic [7:0]  gain_cap_m;

    pix_cmd_t cmd_pending[$];
    pix_res_t pixel_expected[$];
    int       cmds_issued = 0;
    int       cmds_accepted = 0;
    int       fail_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_cycles = 0;

    adaptive_contrast_enhance_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Mirror an index into 0..n-1, repeating the edge pixel
    function automatic longint mirror_index(longint p, longint n);
        int guard = 0;
        if (n <= 1) return 0;
        while ((p < 0 || p >= n) && guard < 64) begin
            if (p < 0) p = -p - 1;
            else       p = 2 * n - 1 - p;
            guard++;
        end
        return p;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint eff_width();
        return (width_m > ace_pkg::FRAME_COLS) ? ace_pkg::FRAME_COLS : width_m;
    endfunction

    function automatic longint eff_height();
        return (height_m > ace_pkg::FRAME_ROWS) ? ace_pkg::FRAME_ROWS : height_m;
    endfunction

    function automatic bit window_reads(logic [5:0] row, logic [5:0] col);
        return !(win_m == 0 || !win_m[0] || win_m > ace_pkg::MAX_WINDOW
                 || row >= eff_height() || col >= eff_width());
    endfunction

    // Expected enhanced pixel for the current frame and registers
    function automatic pix_res_t enhance_pixel(logic [5:0] row, logic [5:0] col);
        pix_res_t r;
        longint w, h, half, n, s, q, rr, cc, v, centre;
        longint mean_q8, var_q16, dev_q8, gmean_q8, gain_q8, cap, total;
        r.enhanced = '0;
        r.flat_window = 1'b0;
        r.error = 1'b0;
        w = eff_width();
        h = eff_height();
        if (!window_reads(row, col)) begin
            r.error = 1'b1;
            return r;
        end
        half = (win_m - 1) / 2;
        n = win_m * win_m;
        s = 0;
        q = 0;
        centre = pix_mem[row * ace_pkg::FRAME_COLS + col];
        for (longint dr = -half; dr <= half; dr++) begin
            rr = mirror_index(row + dr, h);
            for (longint dc = -half; dc <= half; dc++) begin
                cc = mirror_index(col + dc, w);
                v = pix_mem[rr * ace_pkg::FRAME_COLS + cc];
                s += v;
                q += v * v;
            end
        end
        if (n * q == s * s) begin
            r.enhanced = centre[7:0];
            r.flat_window = 1'b1;
            return r;
        end
        mean_q8 = (s * 256) / n;
        var_q16 = ((n * q - s * s) * 65536) / (n * n);
        dev_q8 = longint'(int_sqrt(var_q16));
        if (dev_q8 == 0) dev_q8 = 1;
        gmean_q8 = (longint'(frame_sum_m) * 256) / (w * h);
        gain_q8 = (gmean_q8 * 256) / (5 * dev_q8);
        cap = longint'(gain_cap_m) * 256;
        if (gain_q8 > cap) gain_q8 = cap;
        if (gain_q8 < 256) gain_q8 = 256;
        total = mean_q8 * 256 + gain_q8 * (centre * 256 - mean_q8);
        if (total < 0) r.enhanced = 8'd0;
        else if ((total >>> 16) > 255) r.enhanced = 8'd255;
        else r.enhanced = total[23:16];
        return r;
    endfunction

    // Apply one accepted transaction to the frame model
    function automatic void apply_cmd(pix_cmd_t c);
        int addr;
        addr = c.row * ace_pkg::FRAME_COLS + c.col;
        case (c.opcode)
            ace_pkg::OP_CLEAR: frame_sum_m = '0;
            ace_pkg::OP_LOAD: begin
                if (c.row < eff_height() && c.col < eff_width()) begin
                    pix_mem[addr] = c.pixel_in;
                    pix_written[addr] = 1'b1;
                    frame_sum_m = frame_sum_m + c.pixel_in;
                end
            end
            ace_pkg::OP_ENHANCE: pixel_expected.push_back(enhance_pixel(c.row, c.col));
            default: ;
        endcase
    endfunction

    // Input driver: hold a pending transaction until accepted, idle at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_cmd(cmd_pending.pop_front());
                cmds_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, cmd_pending[0].pixel_in, cmd_pending[0].col,
                                cmd_pending[0].row, cmd_pending[0].opcode};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: long hold-off when asked, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each output transaction with the oldest expected pixel
    always @(posedge aclk) begin
        pix_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_expected.size() == 0) begin
                $error("unexpected output transaction tdata=%h", m_tdata);
                fail_count++;
            end else begin
                exp_r = pixel_expected.pop_front();
                if (m_tdata[7:0] !== exp_r.enhanced) begin
                    $error("enhanced: expected %0d actual %0d", exp_r.enhanced, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[8] !== exp_r.flat_window) begin
                    $error("flat_window: expected %0d actual %0d",
                           exp_r.flat_window, m_tdata[8]);
                    fail_count++;
                end
                if (m_tdata[9] !== exp_r.error) begin
                    $error("error: expected %0d actual %0d", exp_r.error, m_tdata[9]);
                    fail_count++;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Queue one transaction and wait until the block takes it
    task automatic send_item(logic [1:0] opcode, logic [5:0] row, logic [5:0] col,
                             logic [7:0] pixel_in);
        pix_cmd_t c;
        int id;
        c.opcode = opcode;
        c.row = row;
        c.col = col;
        c.pixel_in = pixel_in;
        id = cmds_issued;
        cmds_issued++;
        cmd_pending.push_back(c);
        wait (cmds_accepted > id);
    endtask

    // Enhance a pixel; load any window pixel never written first
    task automatic send_enhance(logic [5:0] row, logic [5:0] col);
        longint half, rr, cc;
        if (window_reads(row, col)) begin
            half = (win_m - 1) / 2;
            for (longint dr = -half; dr <= half; dr++) begin
                rr = mirror_index(row + dr, eff_height());
                for (longint dc = -half; dc <= half; dc++) begin
                    cc = mirror_index(col + dc, eff_width());
                    if (!pix_written[rr * ace_pkg::FRAME_COLS + cc])
                        send_item(ace_pkg::OP_LOAD, rr[5:0], cc[5:0], 8'($urandom));
                end
            end
        end
        send_item(ace_pkg::OP_ENHANCE, row, col, 8'($urandom));
    endtask

    task automatic wait_idle();
        wait (cmd_pending.size() == 0 && pixel_expected.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    // Register write, only while the block is idle
    task automatic set_reg(ace_pkg::cfg_idx_t idx, logic [7:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ace_pkg::CFG_FRAME_WIDTH:  width_m = value[6:0];
            ace_pkg::CFG_FRAME_HEIGHT: height_m = value[6:0];
            ace_pkg::CFG_WINDOW_SIZE:  win_m = value[3:0];
            ace_pkg::CFG_MAX_GAIN:     gain_cap_m = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_frame(logic [7:0] w, logic [7:0] h, logic [7:0] win, logic [7:0] g);
        set_reg(ace_pkg::CFG_FRAME_WIDTH, w);
        set_reg(ace_pkg::CFG_FRAME_HEIGHT, h);
        set_reg(ace_pkg::CFG_WINDOW_SIZE, win);
        set_reg(ace_pkg::CFG_MAX_GAIN, g);
    endtask

    task automatic test_directed();
        // Defaults after reset: corners of the full frame
        send_item(ace_pkg::OP_LOAD, 6'd63, 6'd63, 8'd255);
        send_item(ace_pkg::OP_LOAD, 6'd0, 6'd0, 8'd0);
        send_enhance(6'd0, 6'd0);
        send_enhance(6'd63, 6'd63);
        send_item(OP_UNUSED, 6'd5, 6'd5, 8'hAA);
        send_item(ace_pkg::OP_CLEAR, 6'd0, 6'd0, 8'd0);
        send_enhance(6'd63, 6'd0);
        // Flat window on a 2x2 frame of equal pixels
        set_frame(8'd2, 8'd2, 8'd3, 8'd255);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++)
                send_item(ace_pkg::OP_LOAD, r[5:0], c[5:0], 8'd100);
        send_enhance(6'd1, 6'd1);
        // Small frame: window far larger than the frame
        send_item(ace_pkg::OP_LOAD, 6'd0, 6'd1, 8'd7);
        set_reg(ace_pkg::CFG_WINDOW_SIZE, 8'd15);
        send_enhance(6'd0, 6'd1);
        set_reg(ace_pkg::CFG_MAX_GAIN, 8'd1);
        send_enhance(6'd1, 6'd0);
        // Bad window sizes: even and zero
        set_reg(ace_pkg::CFG_WINDOW_SIZE, 8'd4);
        send_enhance(6'd0, 6'd0);
        set_reg(ace_pkg::CFG_WINDOW_SIZE, 8'd0);
        send_enhance(6'd0, 6'd0);
        // Address outside the frame: ignored load, error on enhance
        set_frame(8'd8, 8'd8, 8'd5, 8'd0);
        send_item(ace_pkg::OP_LOAD, 6'd8, 6'd3, 8'd200);
        send_enhance(6'd3, 6'd8);
        send_enhance(6'd4, 6'd4);
        // Zero width makes every address outside; oversized width acts as full
        set_reg(ace_pkg::CFG_FRAME_WIDTH, 8'd0);
        send_enhance(6'd0, 6'd0);
        set_frame(8'd127, 8'd100, 8'd1, 8'd255);
        send_enhance(6'd63, 6'd63);
    endtask

    // Repeated loads to one pixel all add to the frame sum
    task automatic test_sum_repeat();
        set_frame(8'd2, 8'd1, 8'd3, 8'd255);
        send_item(ace_pkg::OP_CLEAR, 6'd0, 6'd0, 8'd0);
        for (int i = 0; i < 40; i++) send_item(ace_pkg::OP_LOAD, 6'd0, 6'd0, 8'd255);
        send_item(ace_pkg::OP_LOAD, 6'd0, 6'd1, 8'd40);
        send_enhance(6'd0, 6'd0);
        send_enhance(6'd0, 6'd1);
    endtask

    task automatic pick_config();
        logic [7:0] w, h, win, g;
        case ($urandom_range(4))
            0: w = 8'd64;
            1: w = 8'd1;
            2: w = 8'($urandom_range(65, 127));
            default: w = 8'($urandom_range(2, 12));
        endcase
        case ($urandom_range(4))
            0: h = 8'd64;
            1: h = 8'd1;
            default: h = 8'($urandom_range(2, 12));
        endcase
        case ($urandom_range(9))
            0: win = 8'd15;
            1: win = 8'($urandom_range(0, 7) * 2);
            default: win = 8'($urandom_range(0, 3) * 2 + 1);
        endcase
        case ($urandom_range(4))
            0: g = 8'd255;
            1: g = 8'($urandom_range(0, 1));
            default: g = 8'($urandom);
        endcase
        set_frame(w, h, win, g);
    endtask

    task automatic test_random(int n_items);
        int pick, rlim, clim;
        logic [5:0] row, col;
        pick_config();
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 39) pick_config();
            rlim = (eff_height() < 63) ? int'(eff_height() + 1) : 63;
            clim = (eff_width() < 63) ? int'(eff_width() + 1) : 63;
            row = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(0, rlim));
            col = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(0, clim));
            pick = $urandom_range(99);
            if (pick < 3)       send_item(ace_pkg::OP_CLEAR, row, col, 8'($urandom));
            else if (pick < 5)  send_item(OP_UNUSED, row, col, 8'($urandom));
            else if (pick < 55) send_item(ace_pkg::OP_LOAD, row, col, 8'($urandom));
            else                send_enhance(row, col);
        end
    endtask

    // Hold the output off while enhances keep arriving, then pause the sender
    task automatic test_backpressure();
        set_frame(8'd8, 8'd8, 8'd3, 8'd5);
        hold_cycles = 5000;
        for (int i = 0; i < 6; i++)
            send_enhance(6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)));
        wait (pixel_expected.size() == 0);
        for (int i = 0; i < 4; i++)
            send_enhance(6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)));
    endtask

    initial begin
        frame_sum_m = '0;
        width_m = 7'd64;
        height_m = 7'd64;
        win_m = 4'd3;
        gain_cap_m = 8'd5;
        foreach (pix_written[i]) begin
            pix_written[i] = 1'b0;
            pix_mem[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_sum_repeat();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(150);
        send_idle_pct = 55; recv_stall_pct = 0;  test_random(150);
        send_idle_pct = 0;  recv_stall_pct = 55; test_random(150);
        send_idle_pct = 20; recv_stall_pct = 20; test_random(150);
        test_backpressure();

        wait (cmd_pending.size() == 0 && pixel_expected.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
